FILE: sv/sdq_pkg.sv
package sdq_pkg;

    // Sample format.
    localparam int FRAC_BITS = 8;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 16;

    // Sample plus dither: one extra bit so that the sum never wraps.
    localparam int SUM_W = IN_W + 1;

    // Integer part after dropping the fraction, one bit wider for the round-up carry.
    localparam int Q_W = SUM_W - FRAC_BITS + 1;

    // Dither generator.
    localparam int SEED_W = 31;
    localparam logic [SEED_W-1:0] SEED_RESET = SEED_W'(32'h16BA2118);
    localparam logic [SEED_W-1:0] LCG_MUL    = SEED_W'(32'd1103515245);
    localparam logic [SEED_W-1:0] LCG_ADD    = SEED_W'(32'd12345);

    // Rounding and saturation constants.
    localparam logic [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(1 << (FRAC_BITS - 1));
    localparam logic [OUT_W-1:0]     SAT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0]     SAT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_R,
        ST_STEP_L,
        ST_ROUND_R,
        ST_ROUND_L
    } sdq_state_t;

endpackage

FILE: sv/sdq_lcg.sv
module sdq_lcg (
    input  logic [sdq_pkg::SEED_W-1:0] seed_i,
    output logic [sdq_pkg::SEED_W-1:0] seed_next_o
);
    import sdq_pkg::*;

    // One generator step; only the low 31 bits of the product are kept.
    assign seed_next_o = seed_i * LCG_MUL + LCG_ADD;

endmodule

FILE: sv/sdq_round.sv
module sdq_round (
    input  logic signed [sdq_pkg::SUM_W-1:0] value_i,
    output logic        [sdq_pkg::OUT_W-1:0] q_o
);
    import sdq_pkg::*;

    logic signed [Q_W-1:0]       q_floor;
    logic signed [Q_W-1:0]       q_round;
    logic        [FRAC_BITS-1:0] frac;
    logic                        round_up;
    logic                        fits;

    // Split into integer and fraction parts.
    assign q_floor = {value_i[SUM_W-1], value_i[SUM_W-1:FRAC_BITS]};
    assign frac    = value_i[FRAC_BITS-1:0];

    // Round to nearest; an exact half goes to the even integer.
    assign round_up = (frac > FRAC_HALF) || ((frac == FRAC_HALF) && q_floor[0]);
    assign q_round  = q_floor + $signed({{(Q_W-1){1'b0}}, round_up});

    // The value fits when all bits above the 16-bit sign agree.
    assign fits = (q_round[Q_W-1:OUT_W-1] == {(Q_W-OUT_W+1){1'b0}})
               || (q_round[Q_W-1:OUT_W-1] == {(Q_W-OUT_W+1){1'b1}});

    always_comb begin
        if (fits) begin
            q_o = q_round[OUT_W-1:0];
        end else if (q_round[Q_W-1]) begin
            q_o = SAT_MIN;
        end else begin
            q_o = SAT_MAX;
        end
    end

endmodule

FILE: sv/stereo_dither_quantizer.sv
// Stereo dither quantizer.
// Input words arrive on the s_ channel: s_tdata holds the left sample in bits 31:0 and
// the right sample in bits 63:32, both signed with 8 fraction bits; s_tlast marks the
// last pair of a block. Each input word yields exactly one output word on the m_
// channel: m_tdata holds the saturated 16-bit left value in bits 15:0 and the right
// value in bits 31:16, and m_tlast copies s_tlast.
// With dither enabled (cfg_wr_data written through cfg_wr_en, reset value 1), a shared
// LCG step unit advances the 31-bit seed twice per pair, first for right, then for left,
// and the top 8 seed bits are added as dither before rounding. The sequencer sets the
// pace: two generator steps (with dither on only), one rounding step per channel,
// then a return to idle. A new word is accepted once the sequencer returns to idle,
// so each pair is rounded in full before the next one is taken.
// s_tready is high only while idle. A finished word sits in the output register, and
// the next pair may be accepted meanwhile; if the receiver still stalls when that pair
// is rounded, the sequencer holds until the output register frees.
// Reset (aresetn low, synchronous) clears the sequencer, empties the output register,
// reloads the seed and enables dither.
module stereo_dither_quantizer (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: dither enable.
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // left_sample [31:0], right_sample [63:32]
    input  logic        s_tlast,
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // packed_pair [31:0]
    output logic        m_tlast
);
    import sdq_pkg::*;

    sdq_state_t state_reg, state_next;

    logic                    dither_en_reg;
    logic [SEED_W-1:0]       seed_reg;
    logic [SEED_W-1:0]       seed_next;
    logic signed [SUM_W-1:0] right_reg;
    logic signed [SUM_W-1:0] left_reg;
    logic [OUT_W-1:0]        right_q_reg;
    logic                    last_reg;
    logic                    m_tvalid_reg;
    logic [31:0]             m_tdata_reg;
    logic                    m_tlast_reg;

    logic                    in_accept;
    logic                    out_free;
    logic signed [SUM_W-1:0] dither;
    logic signed [SUM_W-1:0] round_in;
    logic [OUT_W-1:0]        round_q;

    // Sequencer controls.
    logic seed_step;
    logic add_right;
    logic add_left;
    logic load_right_q;
    logic load_out;
    logic sel_left;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Dither fraction is the top bits of the current seed.
    assign dither = $signed({{(SUM_W-FRAC_BITS){1'b0}}, seed_reg[SEED_W-1 -: FRAC_BITS]});

    // Shared generator step.
    sdq_lcg u_lcg (
        .seed_i      (seed_reg),
        .seed_next_o (seed_next)
    );

    // Shared rounding and saturation unit: right first, then left.
    assign round_in = sel_left ? left_reg : right_reg;

    sdq_round u_round (
        .value_i (round_in),
        .q_o     (round_q)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = dither_en_reg ? ST_STEP_R : ST_ROUND_R;
                end
            end
            ST_STEP_R:  state_next = ST_STEP_L;
            ST_STEP_L:  state_next = ST_ROUND_R;
            ST_ROUND_R: state_next = ST_ROUND_L;
            ST_ROUND_L: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready     = 1'b0;
        seed_step    = 1'b0;
        add_right    = 1'b0;
        add_left     = 1'b0;
        load_right_q = 1'b0;
        load_out     = 1'b0;
        sel_left     = 1'b0;
        unique case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_STEP_R:  seed_step = 1'b1;
            ST_STEP_L: begin
                seed_step = 1'b1;
                add_right = 1'b1;
            end
            ST_ROUND_R: begin
                add_left     = dither_en_reg;
                load_right_q = 1'b1;
            end
            ST_ROUND_L: begin
                sel_left = 1'b1;
                load_out = out_free;
            end
            default:    s_tready = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dither_en_reg <= 1'b1;
            seed_reg      <= SEED_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                dither_en_reg <= cfg_wr_data;
            end
            if (seed_step) begin
                seed_reg <= seed_next;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Sample datapath.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            left_reg  <= $signed({s_tdata[31], s_tdata[31:0]});
            right_reg <= $signed({s_tdata[63], s_tdata[63:32]});
            last_reg  <= s_tlast;
        end else begin
            if (add_right) begin
                right_reg <= right_reg + dither;
            end
            if (add_left) begin
                left_reg <= left_reg + dither;
            end
        end
        if (load_right_q) begin
            right_q_reg <= round_q;
        end
        if (load_out) begin
            m_tdata_reg <= {right_q_reg, round_q};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
